@@ design/gbc_pkg.sv @@
package gbc_pkg;

   localparam int SAMPLE_W = 16;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] rate_x;
      logic signed [SAMPLE_W-1:0] rate_y;
      logic signed [SAMPLE_W-1:0] rate_z;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] fixed_x;
      logic signed [SAMPLE_W-1:0] fixed_y;
      logic signed [SAMPLE_W-1:0] fixed_z;
      logic                       recalibrated;
      logic                       window_full;
   } rsp_word_type;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VARIANCE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF = 2'd2;

   localparam logic [8:0] LEN_RESET = 9'd100;
   localparam logic [31:0] LIMIT_RESET = 32'd5;
   localparam logic [7:0] HOLDOFF_RESET = 8'd99;
   localparam logic [7:0] COUNT_MAX = 8'd255;

endpackage

@@ design/gbc_fifo.sv @@
module gbc_fifo #(
   parameter int WIDTH = 48,
   parameter int DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [DEPTH_LOG2:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign pop_data = data_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (DEPTH_LOG2+1)'(do_push) - (DEPTH_LOG2+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= push_data;
      end
   end
endmodule

@@ design/gbc_core.sv @@
module gbc_core #(
   parameter int WINDOW_MAX = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [3*SAMPLE_BITS-1:0]     in_data,
   output logic                         in_take,
   output logic                         out_valid,
   output logic [3*SAMPLE_BITS+1:0]     out_data,
   input  logic                         out_take,
   input  logic                         csr_wr_en,
   input  logic [gbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbc_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import gbc_pkg::*;

   localparam int AW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
   localparam int LW = $clog2(WINDOW_MAX + 1);
   localparam int SW = SAMPLE_BITS + LW + 1;
   localparam int QW = 2 * SAMPLE_BITS + LW;
   localparam int DW = QW + LW + 2;
   localparam int PW = SW;
   localparam int CW = 32 + 2 * LW;
   localparam int TW = (DW > CW ? DW : CW) + 1;
   localparam int MW = 2 * SW;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_UPD = 4'd2;
   localparam logic [3:0] ST_SQ = 4'd3;
   localparam logic [3:0] ST_SQW = 4'd4;
   localparam logic [3:0] ST_LSQ = 4'd5;
   localparam logic [3:0] ST_CMP = 4'd6;
   localparam logic [3:0] ST_DIV = 4'd7;
   localparam logic [3:0] ST_OUT = 4'd8;
   localparam logic [3:0] ST_LL = 4'd9;
   localparam logic [3:0] ST_LIM = 4'd10;
   localparam logic [3:0] ST_OLD = 4'd11;
   localparam logic [3:0] ST_DEC = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [LW-1:0] len_ff;
   logic [31:0] limit_ff;
   logic [7:0] holdoff_ff;
   logic signed [SW-1:0] sum_ff [3];
   logic [QW-1:0] sq_ff [3];
   logic [AW-1:0] slot_ff;
   logic filled_ff;
   logic [7:0] settle_ff;
   logic signed [SAMPLE_BITS-1:0] bias_ff [3];
   logic [3*SAMPLE_BITS-1:0] mem [WINDOW_MAX];
   logic [3*SAMPLE_BITS-1:0] old_ff, x_ff;
   logic [1:0] ax_ff;
   logic still_ff;
   logic [MW-1:0] mul_ff;
   logic [TW-1:0] lhs_ff, rhs_ff;
   logic [CW-1:0] ll_ff;
   logic [DW-1:0] lsq_ff;
   logic [PW-1:0] rem_ff, quo_ff, mag_ff;
   logic [LW:0] bit_ff;
   logic latch_ff, full_ff;
   logic [LW-1:0] len_new;
   logic signed [SAMPLE_BITS-1:0] xs, os;
   logic [SW-1:0] smag;
   logic [PW-1:0] rem_sh;
   logic signed [SAMPLE_BITS+1:0] d;
   logic signed [SAMPLE_BITS-1:0] sat [3];

   assign in_take = (state_ff == ST_IDLE) && in_valid && !csr_wr_en;
   assign out_valid = (state_ff == ST_OUT);
   assign out_data = {sat[0], sat[1], sat[2], latch_ff, full_ff};

   always_comb begin
      xs = x_ff[(2-ax_ff)*SAMPLE_BITS +: SAMPLE_BITS];
      os = old_ff[(2-ax_ff)*SAMPLE_BITS +: SAMPLE_BITS];
      smag = sum_ff[ax_ff] < 0 ? SW'(-sum_ff[ax_ff]) : SW'(sum_ff[ax_ff]);
      rem_sh = {rem_ff[PW-2:0], mag_ff[PW-1]};
      len_new = LW'(2);
      if (32'(csr_wr_data[8:0]) > 32'(WINDOW_MAX)) len_new = LW'(WINDOW_MAX);
      else if (csr_wr_data[8:0] >= 9'd2) len_new = LW'(csr_wr_data[8:0]);
      for (int k = 0; k < 3; k++) begin
         d = $signed({{2{x_ff[(2-k)*SAMPLE_BITS+SAMPLE_BITS-1]}},
                      x_ff[(2-k)*SAMPLE_BITS +: SAMPLE_BITS]})
             - (SAMPLE_BITS+2)'(bias_ff[k]);
         if (d > (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1))
            sat[k] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         else if (d < -(SAMPLE_BITS+2)'(1 << (SAMPLE_BITS-1)))
            sat[k] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         else
            sat[k] = d[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (in_take) state_in = ST_READ;
         ST_READ: state_in = ST_OLD;
         ST_OLD: state_in = filled_ff ? ST_DEC : ST_UPD;
         ST_DEC: state_in = ST_UPD;
         ST_UPD: state_in = (ax_ff == 2'd2) ? ST_LL : ST_UPD;
         ST_LL: state_in = ST_LIM;
         ST_LIM: state_in = ST_SQ;
         ST_SQ: state_in = ST_SQW;
         ST_SQW: state_in = ST_LSQ;
         ST_LSQ: state_in = ST_CMP;
         ST_CMP: begin
            if (ax_ff == 2'd2 || !full_ff) state_in = ST_DIV;
            else state_in = ST_SQ;
         end
         ST_DIV: begin
            if (!latch_ff || (ax_ff == 2'd2 && bit_ff == '0)) state_in = ST_OUT;
         end
         ST_OUT: if (out_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= LW'(LEN_RESET);
         limit_ff <= LIMIT_RESET;
         holdoff_ff <= HOLDOFF_RESET;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
            sq_ff[k] <= '0;
            bias_ff[k] <= '0;
         end
         slot_ff <= '0;
         filled_ff <= 1'b0;
         settle_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_WINDOW_LENGTH: begin
                  len_ff <= len_new;
                  for (int k = 0; k < 3; k++) begin
                     sum_ff[k] <= '0;
                     sq_ff[k] <= '0;
                  end
                  slot_ff <= '0;
                  filled_ff <= 1'b0;
               end
               REG_VARIANCE_LIMIT: limit_ff <= csr_wr_data;
               REG_HOLDOFF: holdoff_ff <= csr_wr_data[7:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_DEC: begin
               for (int k = 0; k < 3; k++)
                  sum_ff[k] <= sum_ff[k]
                     - SW'($signed(old_ff[(2-k)*SAMPLE_BITS +: SAMPLE_BITS]));
            end
            ST_UPD: begin
               sq_ff[ax_ff] <= sq_ff[ax_ff]
                  + QW'($unsigned((2*SAMPLE_BITS)'(xs) * (2*SAMPLE_BITS)'(xs)))
                  - (filled_ff ? QW'($unsigned((2*SAMPLE_BITS)'(os) * (2*SAMPLE_BITS)'(os)))
                               : QW'(0));
               if (ax_ff == 2'd0) begin
                  for (int k = 0; k < 3; k++)
                     sum_ff[k] <= sum_ff[k]
                        + SW'($signed(x_ff[(2-k)*SAMPLE_BITS +: SAMPLE_BITS]));
               end
               if (ax_ff == 2'd2) begin
                  if (32'(slot_ff) + 32'd1 >= 32'(len_ff)) begin
                     slot_ff <= '0;
                     filled_ff <= 1'b1;
                  end else begin
                     slot_ff <= slot_ff + 1'b1;
                  end
               end
            end
            ST_DIV: begin
               if (ax_ff == 2'd0 && bit_ff == LW'(PW)) begin
                  if (latch_ff) settle_ff <= '0;
                  else if (settle_ff != COUNT_MAX) settle_ff <= settle_ff + 1'b1;
               end
               if (latch_ff && bit_ff == '0)
                  bias_ff[ax_ff] <= sum_ff[ax_ff] < 0 ? SAMPLE_BITS'(-quo_ff)
                                                      : SAMPLE_BITS'(quo_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) x_ff <= in_data;
      if (state_ff == ST_READ) old_ff <= mem[slot_ff];
      if (state_ff == ST_OLD) mem[slot_ff] <= x_ff;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_OLD: ax_ff <= 2'd0;
         ST_UPD: ax_ff <= ax_ff + 2'd1;
         ST_LL: begin
            ax_ff <= 2'd0;
            ll_ff <= CW'(len_ff) * CW'(len_ff);
            full_ff <= filled_ff;
            still_ff <= filled_ff;
         end
         ST_LIM: ll_ff <= CW'(ll_ff[2*LW-1:0]) * CW'(limit_ff);
         ST_SQ: mul_ff <= MW'(smag) * MW'(smag);
         ST_SQW: lsq_ff <= DW'(sq_ff[ax_ff]) * DW'(len_ff);
         ST_LSQ: begin
            lhs_ff <= TW'(lsq_ff) - TW'(mul_ff);
            rhs_ff <= TW'(ll_ff);
         end
         ST_CMP: begin
            if (!(lhs_ff < rhs_ff)) still_ff <= 1'b0;
            if (ax_ff == 2'd2 || !full_ff) begin
               ax_ff <= 2'd0;
               bit_ff <= (LW+1)'(PW);
               latch_ff <= full_ff && still_ff && (lhs_ff < rhs_ff)
                           && settle_ff >= holdoff_ff;
               mag_ff <= sum_ff[0] < 0 ? PW'(-sum_ff[0]) : PW'(sum_ff[0]);
               rem_ff <= '0;
            end else begin
               ax_ff <= ax_ff + 2'd1;
            end
         end
         ST_DIV: begin
            if (bit_ff != '0) begin
               bit_ff <= bit_ff - 1'b1;
               mag_ff <= {mag_ff[PW-2:0], 1'b0};
               if (rem_sh >= PW'(len_ff)) begin
                  rem_ff <= rem_sh - PW'(len_ff);
                  quo_ff <= {quo_ff[PW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[PW-2:0], 1'b0};
               end
            end else if (ax_ff != 2'd2) begin
               ax_ff <= ax_ff + 2'd1;
               bit_ff <= (LW+1)'(PW);
               rem_ff <= '0;
               mag_ff <= sum_ff[ax_ff+2'd1] < 0 ? PW'(-sum_ff[ax_ff+2'd1])
                                                  : PW'(sum_ff[ax_ff+2'd1]);
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end
endmodule

@@ design/gyro_bias_calibrator.sv @@
// a word spends longer in the back end once the window is full, and longer still
// when the bias latches (restoring divider, one axis after another)
// the back end takes one word at a time and takes no new one until the last is out;
// the input and output queues hold two words each
// reset: synchronous, active high; registers return to reset values, sums cleared
// the sample store is not cleared; window filling writes before it reads
module gyro_bias_calibrator #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  gbc_pkg::req_word_type          req_word,
   output logic                           full,
   output logic                           empty,
   input  logic                           pop,
   output gbc_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_wr_en,
   input  logic [gbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbc_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import gbc_pkg::*;

   localparam int SAMPLE_BITS = SAMPLE_W;

   logic q_empty, q_take, c_valid;
   logic [3*SAMPLE_BITS-1:0] q_data;
   logic [3*SAMPLE_BITS+1:0] c_data;
   logic o_full;

   gbc_fifo #(.WIDTH(3*SAMPLE_BITS), .DEPTH_LOG2(1)) u_in_q (
      .clock(clock), .reset(reset), .push(req_push), .push_data(req_word),
      .full(full), .pop(q_take), .pop_data(q_data), .empty(q_empty));

   gbc_core #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_core (
      .clock(clock), .reset(reset), .in_valid(!q_empty), .in_data(q_data),
      .in_take(q_take), .out_valid(c_valid), .out_data(c_data), .out_take(!o_full),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data));

   gbc_fifo #(.WIDTH(3*SAMPLE_BITS+2), .DEPTH_LOG2(1)) u_out_q (
      .clock(clock), .reset(reset), .push(c_valid), .push_data(c_data),
      .full(o_full), .pop(pop), .pop_data(rsp_word), .empty(empty));
endmodule

@@ design/gbc_checker.sv @@
module gbc_props (
   input logic clock,
   input logic reset,
   input logic full,
   input logic empty,
   input logic pop,
   input gbc_pkg::rsp_word_type rsp_word
);
   import gbc_pkg::*;

   a_empty_rst: assert property (@(posedge clock) reset |=> empty) else $error("empty");
   a_full_rst: assert property (@(posedge clock) reset |=> !full) else $error("full");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_word)) else $error("hold");
   a_recal_full: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.recalibrated) |-> rsp_word.window_full) else $error("recal");
endmodule

bind gyro_bias_calibrator gbc_props u_chk (
   .clock(clock), .reset(reset), .full(full),
   .empty(empty), .pop(pop), .rsp_word(rsp_word));

@@ tb/gbc_checker.sv @@
`timescale 1ns / 1ps

module gbc_checker
   import gbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_word_type          req_word,
   input  logic                  full,
   input  logic                  empty,
   input  logic                  pop,
   input  rsp_word_type          rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    errors
);

   localparam int DEPTH = 256;

   int unsigned   win_len;
   longint        still_limit;
   int unsigned   settle_need;
   int            rate_hist [DEPTH][3];
   longint        rate_sum [3];
   longint        rate_sq_sum [3];
   int unsigned   slot_ptr;
   bit            win_filled;
   int unsigned   settle_cnt;
   int            offset [3];
   rsp_word_type  fixed_pending [$];

   task automatic restart_window();
      for (int k = 0; k < 3; k++) begin
         rate_sum[k] = 0;
         rate_sq_sum[k] = 0;
      end
      slot_ptr = 0;
      win_filled = 0;
   endtask

   function automatic logic signed [15:0] clip16(longint d);
      if (d > 32767) return 16'sd32767;
      if (d < -32768) return -16'sd32768;
      return d[15:0];
   endfunction

   function automatic rsp_word_type remove_bias(req_word_type w);
      rsp_word_type r;
      int           x [3];
      bit           still;
      longint       l;
      x[0] = w.rate_x;
      x[1] = w.rate_y;
      x[2] = w.rate_z;
      for (int k = 0; k < 3; k++) begin
         if (win_filled) begin
            rate_sum[k] -= rate_hist[slot_ptr][k];
            rate_sq_sum[k] -= longint'(rate_hist[slot_ptr][k]) * rate_hist[slot_ptr][k];
         end
         rate_hist[slot_ptr][k] = x[k];
         rate_sum[k] += x[k];
         rate_sq_sum[k] += longint'(x[k]) * x[k];
      end
      slot_ptr++;
      if (slot_ptr >= win_len) begin
         slot_ptr = 0;
         win_filled = 1;
      end
      l = win_len;
      still = win_filled;
      for (int k = 0; k < 3; k++)
         if (!(l * rate_sq_sum[k] - rate_sum[k] * rate_sum[k] < still_limit * l * l))
            still = 0;
      r.recalibrated = 0;
      if (still && settle_cnt >= settle_need) begin
         for (int k = 0; k < 3; k++) offset[k] = rate_sum[k] / l;
         settle_cnt = 0;
         r.recalibrated = 1;
      end else if (settle_cnt < COUNT_MAX) begin
         settle_cnt++;
      end
      r.fixed_x = clip16(longint'(x[0]) - offset[0]);
      r.fixed_y = clip16(longint'(x[1]) - offset[1]);
      r.fixed_z = clip16(longint'(x[2]) - offset[2]);
      r.window_full = win_filled;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         win_len = LEN_RESET;
         still_limit = LIMIT_RESET;
         settle_need = HOLDOFF_RESET;
         restart_window();
         settle_cnt = 0;
         for (int k = 0; k < 3; k++) offset[k] = 0;
         fixed_pending.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_WINDOW_LENGTH: begin
                  win_len = csr_wr_data[8:0];
                  if (win_len < 2) win_len = 2;
                  if (win_len > DEPTH) win_len = DEPTH;
                  restart_window();
               end
               REG_VARIANCE_LIMIT: still_limit = csr_wr_data;
               REG_HOLDOFF: settle_need = csr_wr_data[7:0];
               default: ;
            endcase
         end
         if (req_push && !full) fixed_pending.push_back(remove_bias(req_word));
         if (pop && !empty) begin
            if (fixed_pending.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               e = fixed_pending.pop_front();
               if (rsp_word.fixed_x !== e.fixed_x)
                  report_mismatch("fixed_x", rsp_word.fixed_x, e.fixed_x);
               if (rsp_word.fixed_y !== e.fixed_y)
                  report_mismatch("fixed_y", rsp_word.fixed_y, e.fixed_y);
               if (rsp_word.fixed_z !== e.fixed_z)
                  report_mismatch("fixed_z", rsp_word.fixed_z, e.fixed_z);
               if (rsp_word.recalibrated !== e.recalibrated)
                  report_mismatch("recalibrated", rsp_word.recalibrated, e.recalibrated);
               if (rsp_word.window_full !== e.window_full)
                  report_mismatch("window_full", rsp_word.window_full, e.window_full);
            end
         end
      end
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import gbc_pkg::*;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_push = 0;
   req_word_type          req_word = '0;
   logic                  full;
   logic                  empty;
   logic                  pop = 0;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   int                    errors;

   int  pushed = 0;
   int  popped = 0;
   bit  calm = 0;
   bit  hold_rsp = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   gyro_bias_calibrator DUT (.*);

   gbc_checker u_checker (.*);

   always @(posedge clock) if (!reset && pop && !empty) popped++;

   // receiver side, with one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            pop <= 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         pop <= calm || ($urandom_range(99) >= 25);
      end
   end

   task automatic send_word(req_word_type w);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 25) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_word <= w;
      do @(posedge clock); while (full);
      pushed++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_push <= 0;
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_push <= 0;
      while (popped != pushed) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [15:0] near(logic [15:0] base, int amp);
      int v;
      v = $signed(base) + $signed($urandom_range(2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   initial begin
      req_word_type w;
      logic [15:0]  bx, by, bz;
      int           amp, run, total, phase, n;
      logic [8:0]   lens [7];
      lens = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd256, 9'd511, 9'd8};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: saturation both ways with the smallest window
      write_reg(REG_WINDOW_LENGTH, 2);
      write_reg(REG_VARIANCE_LIMIT, 32'hFFFF_FFFF);
      write_reg(REG_HOLDOFF, 0);
      repeat (2) send_word('{16'h8000, 16'h8000, 16'h8000});
      send_word('{16'h7FFF, 16'h7FFF, 16'h7FFF});
      repeat (3) send_word('{16'h7FFF, 16'h7FFF, 16'h7FFF});
      send_word('{16'h8000, 16'h8000, 16'h8000});
      send_word('{16'h0000, 16'hFFFF, 16'h0001});
      drain();
      write_reg(REG_VARIANCE_LIMIT, 0);
      write_reg(REG_HOLDOFF, 255);
      repeat (6) send_word('{16'h1234, 16'h8000, 16'h7FFF});
      drain();

      total = 0;
      phase = 0;
      while (total < 2000) begin
         write_reg(REG_WINDOW_LENGTH,
                   (phase < 7) ? lens[phase] : $urandom_range(2, 20));
         case ($urandom_range(3))
            0: write_reg(REG_VARIANCE_LIMIT, 32'hFFFF_FFFF);
            1: write_reg(REG_VARIANCE_LIMIT, 0);
            default: write_reg(REG_VARIANCE_LIMIT, $urandom_range(40));
         endcase
         case ($urandom_range(3))
            0: write_reg(REG_HOLDOFF, 0);
            1: write_reg(REG_HOLDOFF, 255);
            default: write_reg(REG_HOLDOFF, $urandom_range(12));
         endcase
         calm = (phase % 4 == 2);
         if (phase == 3) hold_rsp = 1;
         n = (phase == 4 || phase == 5) ? 600 : $urandom_range(60, 160);
         while (n > 0) begin
            bx = 16'($urandom);
            by = 16'($urandom);
            bz = 16'($urandom);
            if ($urandom_range(3) == 0) begin
               bx = {bx[15], {15{bx[15]}}} ^ 16'h0003;
               by = {by[15], {15{by[15]}}} ^ 16'h0001;
            end
            amp = $urandom_range(3);
            run = $urandom_range(4, 40);
            for (int i = 0; i < run && n > 0; i++) begin
               if ($urandom_range(9) == 0) begin
                  w = {16'($urandom), 16'($urandom), 16'($urandom)};
               end else begin
                  w.rate_x = near(bx, amp);
                  w.rate_y = near(by, amp);
                  w.rate_z = near(bz, amp);
               end
               send_word(w);
               n--;
               total++;
            end
         end
         drain();
         calm = 0;
         phase++;
      end

      if (errors == 0 && popped == pushed)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_top failed");
      $finish;
   end

endmodule
